// ===== design/mrs_pkg.sv =====
// ----------------------------------------------------------------------------
// mrs_pkg
// Shared constants, types and the CRC-16 byte update for the Modbus RTU
// register slave core.
// ----------------------------------------------------------------------------
package mrs_pkg;

   // Sizes
   localparam int NUM_REGS    = 16;
   localparam int FRAME_BYTES = 64;
   localparam int REG_BYTES   = 2 * NUM_REGS;
   localparam int LEN_W       = $clog2(FRAME_BYTES + 1);
   localparam int FADDR_W     = $clog2(FRAME_BYTES);
   localparam int RADDR_W     = $clog2(REG_BYTES);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Frame layout
   localparam int HDR_BYTES     = 6;
   localparam int MIN_FRAME     = 5;
   localparam int MIN_CMD_FRAME = 8;
   localparam int WR_DATA_OFS   = 7;
   localparam int WRM_OVERHEAD  = 9;
   localparam int RD_HDR_BYTES  = 3;

   // Function codes
   localparam logic [7:0] FN_READ_HOLD  = 8'd3;
   localparam logic [7:0] FN_READ_INPUT = 8'd4;
   localparam logic [7:0] FN_WRITE_ONE  = 8'd6;
   localparam logic [7:0] FN_WRITE_MULT = 8'd16;

   // CRC
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // Validated request, header bytes 0..5
   typedef struct packed {
      logic [HDR_BYTES-1:0][7:0] hdr;
   } cmd_type;

   // Queue status toward the front
   typedef struct packed {
      logic full;
      logic empty;
      logic has_mult;
   } q_stat_type;

   // Back status toward the front
   typedef struct packed {
      logic copy_busy;
   } back_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_SEND,
      ST_CRC_LO,
      ST_CRC_HI
   } back_state_type;

   // One byte of the reflected CRC-16 update
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== design/mrs_queue.sv =====
// ----------------------------------------------------------------------------
// mrs_queue
// Short command queue between the frame checker and the executor.
// ----------------------------------------------------------------------------
module mrs_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  mrs_pkg::cmd_type    push_cmd,
   input  logic                pop,
   output mrs_pkg::cmd_type    head_cmd,
   output mrs_pkg::q_stat_type stat
);

   mrs_pkg::cmd_type                  slot_ff [mrs_pkg::QUEUE_DEPTH];
   logic [mrs_pkg::QUEUE_DEPTH-1:0]   vld_ff, vld_in;
   logic [mrs_pkg::QPTR_W-1:0]        wp_ff, wp_in, rp_ff, rp_in;
   logic [mrs_pkg::QCNT_W-1:0]        cnt_ff, cnt_in;
   logic                              has_mult;

   // pointer and count update
   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      vld_in = vld_ff;
      if (push) begin
         wp_in         = (wp_ff == mrs_pkg::QPTR_W'(mrs_pkg::QUEUE_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
         vld_in[wp_ff] = 1'b1;
      end
      if (pop) begin
         rp_in         = (rp_ff == mrs_pkg::QPTR_W'(mrs_pkg::QUEUE_DEPTH - 1)) ? '0 : rp_ff + 1'b1;
         vld_in[rp_ff] = 1'b0;
      end
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (!push && pop) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
         vld_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
         vld_ff <= vld_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) slot_ff[wp_ff] <= push_cmd;
   end

   // any queued multiple write still needs the frame buffer
   always_comb begin
      has_mult = 1'b0;
      for (int i = 0; i < mrs_pkg::QUEUE_DEPTH; i++) begin
         if (vld_ff[i] && slot_ff[i].hdr[1] == mrs_pkg::FN_WRITE_MULT) has_mult = 1'b1;
      end
   end

   assign head_cmd      = slot_ff[rp_ff];
   assign stat.full     = (cnt_ff == mrs_pkg::QCNT_W'(mrs_pkg::QUEUE_DEPTH));
   assign stat.empty    = (cnt_ff == '0);
   assign stat.has_mult = has_mult;

endmodule

// ===== design/mrs_front.sv =====
// ----------------------------------------------------------------------------
// mrs_front
// Collects request words into the frame buffer, runs the CRC as bytes
// arrive and checks the frame at its end mark.
// ----------------------------------------------------------------------------
module mrs_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_rx_byte,
   input  logic                          req_frame_end,
   input  mrs_pkg::q_stat_type           q_stat,
   input  mrs_pkg::back_stat_type        back_stat,
   output logic                          push,
   output mrs_pkg::cmd_type              push_cmd,
   input  logic [mrs_pkg::FADDR_W-1:0]   rd_addr,
   output logic [7:0]                    rd_data
);

   logic [7:0]                 mem [mrs_pkg::FRAME_BYTES];
   logic [7:0]                 rd_data_ff;
   logic [mrs_pkg::LEN_W-1:0]  len_ff, len_in, len_now;
   logic                       ovf_ff, ovf_in, ovf_now;
   logic [15:0]                crc_all_ff, crc_all_in, crc_lag_ff, crc_lag_in;
   logic [7:0]                 prev_ff, prev_in;
   mrs_pkg::cmd_type           hdr_ff;
   logic                       accept, store, ok, fn_ok;
   logic [7:0]                 fn, start, count;
   logic [8:0]                 span;
   logic [9:0]                 need;

   assign req_stall = q_stat.full || q_stat.has_mult || back_stat.copy_busy;
   assign accept    = req_valid && !req_stall;
   assign store     = accept && (len_ff < mrs_pkg::LEN_W'(mrs_pkg::FRAME_BYTES));

   // frame buffer, written per stored word, read by the executor
   always_ff @(posedge clock) begin
      if (store) mem[len_ff[mrs_pkg::FADDR_W-1:0]] <= req_rx_byte;
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;

   // header capture
   always_ff @(posedge clock) begin
      if (store && len_ff < mrs_pkg::LEN_W'(mrs_pkg::HDR_BYTES))
         hdr_ff.hdr[len_ff[2:0]] <= req_rx_byte;
   end

   // frame check at the end mark
   assign len_now = store ? len_ff + 1'b1 : len_ff;
   assign ovf_now = ovf_ff || (accept && !store);
   assign fn      = hdr_ff.hdr[1];
   assign start   = hdr_ff.hdr[3];
   assign count   = hdr_ff.hdr[5];
   assign span    = {1'b0, start} + {1'b0, count};
   assign need    = 10'(mrs_pkg::WRM_OVERHEAD) + {1'b0, count, 1'b0};

   always_comb begin
      unique case (fn)
         mrs_pkg::FN_READ_HOLD,
         mrs_pkg::FN_READ_INPUT: fn_ok = (span <= 9'(mrs_pkg::NUM_REGS));
         mrs_pkg::FN_WRITE_ONE:  fn_ok = (start < 8'(mrs_pkg::NUM_REGS));
         mrs_pkg::FN_WRITE_MULT: fn_ok = (span <= 9'(mrs_pkg::NUM_REGS))
                                         && ({3'b000, len_now} >= need);
         default:                fn_ok = 1'b0;
      endcase
   end

   assign ok = !ovf_now
               && len_now >= mrs_pkg::LEN_W'(mrs_pkg::MIN_CMD_FRAME)
               && crc_lag_ff == {req_rx_byte, prev_ff}
               && fn_ok;

   assign push     = accept && req_frame_end && ok;
   assign push_cmd = hdr_ff;

   // running CRC, lagging by one byte for the check
   always_comb begin
      len_in     = len_ff;
      ovf_in     = ovf_ff;
      crc_all_in = crc_all_ff;
      crc_lag_in = crc_lag_ff;
      prev_in    = prev_ff;
      if (store) begin
         len_in     = len_now;
         crc_all_in = mrs_pkg::crc_byte(crc_all_ff, req_rx_byte);
         crc_lag_in = crc_all_ff;
         prev_in    = req_rx_byte;
      end
      if (accept && !store) ovf_in = 1'b1;
      if (accept && req_frame_end) begin
         len_in     = '0;
         ovf_in     = 1'b0;
         crc_all_in = mrs_pkg::CRC_INIT;
         crc_lag_in = mrs_pkg::CRC_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= '0;
         ovf_ff     <= 1'b0;
         crc_all_ff <= mrs_pkg::CRC_INIT;
         crc_lag_ff <= mrs_pkg::CRC_INIT;
      end else begin
         len_ff     <= len_in;
         ovf_ff     <= ovf_in;
         crc_all_ff <= crc_all_in;
         crc_lag_ff <= crc_lag_in;
      end
      prev_ff <= prev_in;
   end

endmodule

// ===== design/mrs_back.sv =====
// ----------------------------------------------------------------------------
// mrs_back
// Executes checked requests: register writes, then the response burst
// with its trailing CRC.
// ----------------------------------------------------------------------------
module mrs_back (
   input  logic                          clock,
   input  logic                          reset,
   input  mrs_pkg::q_stat_type           q_stat,
   input  mrs_pkg::cmd_type              head_cmd,
   output logic                          pop,
   output mrs_pkg::back_stat_type        back_stat,
   output logic [mrs_pkg::FADDR_W-1:0]   rd_addr,
   input  logic [7:0]                    rd_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_tx_byte,
   output logic                          rsp_tx_last
);

   mrs_pkg::back_state_type        state_ff, state_in;
   mrs_pkg::cmd_type               cmd_ff;
   logic [7:0]                     regs_ff [mrs_pkg::REG_BYTES];
   logic [5:0]                     idx_ff, idx_in, n_last;
   logic [mrs_pkg::RADDR_W-1:0]    rp_ff, rp_in;
   logic [mrs_pkg::FADDR_W-1:0]    src_ff, src_in;
   logic [15:0]                    crc_ff, crc_in;
   logic                           out_v_ff;
   logic [7:0]                     out_b_ff;
   logic                           out_l_ff;
   logic                           out_free, emit, emit_last;
   logic [7:0]                     emit_byte, send_byte;
   logic                           is_rd, head_mult;
   logic [5:0]                     cnt2;

   assign out_free  = !out_v_ff || !rsp_stall;
   assign is_rd     = (cmd_ff.hdr[1] == mrs_pkg::FN_READ_HOLD)
                      || (cmd_ff.hdr[1] == mrs_pkg::FN_READ_INPUT);
   assign cnt2      = {cmd_ff.hdr[5][4:0], 1'b0};
   assign n_last    = is_rd ? 6'(mrs_pkg::RD_HDR_BYTES) + cnt2 - 1'b1
                            : 6'(mrs_pkg::HDR_BYTES - 1);
   assign head_mult = (head_cmd.hdr[1] == mrs_pkg::FN_WRITE_MULT)
                      && (head_cmd.hdr[5] != 8'd0);
   assign rd_addr   = src_ff;
   assign back_stat.copy_busy = (state_ff == mrs_pkg::ST_COPY_RD)
                                || (state_ff == mrs_pkg::ST_COPY_WR);

   // response byte in the body
   always_comb begin
      if (is_rd) begin
         case (idx_ff)
            6'd0:    send_byte = cmd_ff.hdr[0];
            6'd1:    send_byte = cmd_ff.hdr[1];
            6'd2:    send_byte = {cmd_ff.hdr[5][6:0], 1'b0};
            default: send_byte = regs_ff[rp_ff];
         endcase
      end else begin
         send_byte = cmd_ff.hdr[idx_ff[2:0]];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mrs_pkg::ST_IDLE:
            if (!q_stat.empty) state_in = head_mult ? mrs_pkg::ST_COPY_RD : mrs_pkg::ST_SEND;
         mrs_pkg::ST_COPY_RD: state_in = mrs_pkg::ST_COPY_WR;
         mrs_pkg::ST_COPY_WR:
            state_in = (idx_ff == cnt2 - 1'b1) ? mrs_pkg::ST_SEND : mrs_pkg::ST_COPY_RD;
         mrs_pkg::ST_SEND:
            if (out_free && idx_ff == n_last) state_in = mrs_pkg::ST_CRC_LO;
         mrs_pkg::ST_CRC_LO:
            if (out_free) state_in = mrs_pkg::ST_CRC_HI;
         mrs_pkg::ST_CRC_HI:
            if (out_free) state_in = mrs_pkg::ST_IDLE;
         default: state_in = mrs_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      pop       = 1'b0;
      emit      = 1'b0;
      emit_last = 1'b0;
      emit_byte = send_byte;
      unique case (state_ff)
         mrs_pkg::ST_IDLE:    pop = !q_stat.empty;
         mrs_pkg::ST_SEND:    emit = out_free;
         mrs_pkg::ST_CRC_LO: begin
            emit      = out_free;
            emit_byte = crc_ff[7:0];
         end
         mrs_pkg::ST_CRC_HI: begin
            emit      = out_free;
            emit_last = 1'b1;
            emit_byte = crc_ff[15:8];
         end
         default: ;
      endcase
   end

   // counters and CRC
   always_comb begin
      idx_in = idx_ff;
      rp_in  = rp_ff;
      src_in = src_ff;
      crc_in = crc_ff;
      case (state_ff)
         mrs_pkg::ST_IDLE: begin
            idx_in = '0;
            rp_in  = mrs_pkg::RADDR_W'({head_cmd.hdr[3], 1'b0});
            src_in = mrs_pkg::FADDR_W'(mrs_pkg::WR_DATA_OFS);
            crc_in = mrs_pkg::CRC_INIT;
         end
         mrs_pkg::ST_COPY_WR: begin
            rp_in  = rp_ff + 1'b1;
            src_in = src_ff + 1'b1;
            idx_in = (idx_ff == cnt2 - 1'b1) ? '0 : idx_ff + 1'b1;
            if (idx_ff == cnt2 - 1'b1) rp_in = mrs_pkg::RADDR_W'({cmd_ff.hdr[3], 1'b0});
         end
         mrs_pkg::ST_SEND: begin
            if (out_free) begin
               crc_in = mrs_pkg::crc_byte(crc_ff, send_byte);
               idx_in = idx_ff + 1'b1;
               if (is_rd && idx_ff >= 6'(mrs_pkg::RD_HDR_BYTES)) rp_in = rp_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= mrs_pkg::ST_IDLE;
      else       state_ff <= state_in;
      idx_ff <= idx_in;
      rp_ff  <= rp_in;
      src_ff <= src_in;
      crc_ff <= crc_in;
      if (pop) cmd_ff <= head_cmd;
   end

   // register store: single write at pop, multiple write during copy
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mrs_pkg::REG_BYTES; i++) regs_ff[i] <= 8'h00;
      end else if (pop && head_cmd.hdr[1] == mrs_pkg::FN_WRITE_ONE) begin
         regs_ff[mrs_pkg::RADDR_W'({head_cmd.hdr[3], 1'b0})]        <= head_cmd.hdr[4];
         regs_ff[mrs_pkg::RADDR_W'({head_cmd.hdr[3], 1'b0}) + 1'b1] <= head_cmd.hdr[5];
      end else if (state_ff == mrs_pkg::ST_COPY_WR) begin
         regs_ff[rp_ff] <= rd_data;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (emit) out_v_ff <= 1'b1;
      else if (!rsp_stall) out_v_ff <= 1'b0;
      if (emit) begin
         out_b_ff <= emit_byte;
         out_l_ff <= emit_last;
      end
   end

   assign rsp_valid   = out_v_ff;
   assign rsp_tx_byte = out_b_ff;
   assign rsp_tx_last = out_l_ff;

endmodule

// ===== design/modbus_rtu_register_slave_core.sv =====
// ----------------------------------------------------------------------------
// modbus_rtu_register_slave_core
// Modbus RTU slave over 16 holding registers (functions 3, 4, 6, 16).
// ----------------------------------------------------------------------------
// Request words are taken one per cycle when not stalled into a 64-byte frame
// buffer while the CRC runs alongside. At the end mark the frame is checked in
// the same cycle and a good request goes into a two-entry queue. The executor
// then copies each data byte of a multiple write in a read state and a write
// state (one frame buffer read port), and it sends one response byte per cycle
// while the receiver does not stall, up to 37 bytes. Input stalls while the
// queue is full or a multiple write still needs the frame buffer. Bad, short,
// overflowed or unknown frames give no response.
module modbus_rtu_register_slave_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       req_frame_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_tx_last
);

   mrs_pkg::q_stat_type            q_stat;
   mrs_pkg::back_stat_type         back_stat;
   mrs_pkg::cmd_type               push_cmd, head_cmd;
   logic                           push, pop;
   logic [mrs_pkg::FADDR_W-1:0]    rd_addr;
   logic [7:0]                     rd_data;

   mrs_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_rx_byte, .req_frame_end,
      .q_stat, .back_stat, .push, .push_cmd, .rd_addr, .rd_data
   );

   mrs_queue u_queue (
      .clock, .reset, .push, .push_cmd, .pop, .head_cmd, .stat(q_stat)
   );

   mrs_back u_back (
      .clock, .reset, .q_stat, .head_cmd, .pop, .back_stat, .rd_addr, .rd_data,
      .rsp_valid, .rsp_stall, .rsp_tx_byte, .rsp_tx_last
   );

endmodule

// ===== design/mrs_checker.sv =====
// ----------------------------------------------------------------------------
// mrs_assertions
// Port-level checks for the register slave core.
// ----------------------------------------------------------------------------
module mrs_assertions (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_tx_byte,
   input logic       rsp_tx_last
);

   // nothing pending right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("output active after reset");

   // a stalled request word stays offered
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid)
      else $error("stalled request word withdrawn");

   // stalled word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_tx_byte) && $stable(rsp_tx_last))
      else $error("stalled response word changed");

   // offered response words are fully known
   a_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown({rsp_tx_byte, rsp_tx_last}))
      else $error("unknown bits in response word");

endmodule

bind modbus_rtu_register_slave_core mrs_assertions u_mrs_assertions (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .rsp_tx_byte, .rsp_tx_last
);

// ===== bench/mrs_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mrs_checker
// Watches both channels of the Modbus RTU register slave core, predicts the
// response words of every request frame and compares them in order.
// ----------------------------------------------------------------------------
module mrs_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       req_frame_end,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_tx_byte,
   input  logic       rsp_tx_last,
   output int         fail_count,
   output int         pending,
   output int         words_checked
);

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       tx_last;
   } resp_word_type;

   logic [7:0]    frame_buf [mrs_pkg::FRAME_BYTES];
   int            frame_len;
   logic          frame_ovf;
   logic [7:0]    reg_image [mrs_pkg::REG_BYTES];
   resp_word_type resp_due [$];

   // Modbus CRC-16 over the first len bytes of a queue
   function automatic logic [15:0] modbus_crc(input logic [7:0] data [$], input int len);
      logic [15:0] c;
      c = 16'hFFFF;
      for (int k = 0; k < len; k++) begin
         c ^= {8'h00, data[k]};
         for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
         end
      end
      return c;
   endfunction

   // Execute a completed frame and queue its response words
   task automatic run_frame();
      logic [7:0]  f [$];
      logic [7:0]  r [$];
      logic [15:0] c;
      logic [7:0]  fn;
      int          start, count;
      for (int k = 0; k < frame_len; k++) f.push_back(frame_buf[k]);
      if (frame_ovf || frame_len < mrs_pkg::MIN_FRAME) return;
      c = modbus_crc(f, frame_len - 2);
      if (f[frame_len-2] != c[7:0] || f[frame_len-1] != c[15:8]) return;
      fn = f[1];
      if (fn != mrs_pkg::FN_READ_HOLD && fn != mrs_pkg::FN_READ_INPUT &&
          fn != mrs_pkg::FN_WRITE_ONE && fn != mrs_pkg::FN_WRITE_MULT) return;
      if (frame_len < mrs_pkg::MIN_CMD_FRAME) return;
      start = f[3];
      count = f[5];
      if (fn == mrs_pkg::FN_READ_HOLD || fn == mrs_pkg::FN_READ_INPUT) begin
         if (start + count > mrs_pkg::NUM_REGS) return;
         r.push_back(f[0]);
         r.push_back(fn);
         r.push_back(8'(2 * count));
         for (int i = 0; i < 2 * count; i++) r.push_back(reg_image[2 * start + i]);
      end else begin
         if (fn == mrs_pkg::FN_WRITE_ONE) begin
            if (start >= mrs_pkg::NUM_REGS) return;
            reg_image[2 * start]     = f[4];
            reg_image[2 * start + 1] = f[5];
         end else begin
            if (start + count > mrs_pkg::NUM_REGS) return;
            if (frame_len < mrs_pkg::WRM_OVERHEAD + 2 * count) return;
            for (int i = 0; i < 2 * count; i++)
               reg_image[2 * start + i] = f[mrs_pkg::WR_DATA_OFS + i];
         end
         for (int i = 0; i < mrs_pkg::HDR_BYTES; i++) r.push_back(f[i]);
      end
      c = modbus_crc(r, r.size());
      r.push_back(c[7:0]);
      r.push_back(c[15:8]);
      foreach (r[i]) resp_due.push_back('{tx_byte: r[i], tx_last: (i == r.size() - 1)});
   endtask

   // Track request words, then check response words against the oldest due
   always @(posedge clock) begin
      resp_word_type exp_w;
      if (reset) begin
         frame_len = 0;
         frame_ovf = 1'b0;
         for (int i = 0; i < mrs_pkg::REG_BYTES; i++) reg_image[i] = 8'h00;
         resp_due.delete();
         fail_count = 0;
         words_checked = 0;
      end else begin
         if (req_valid && !req_stall) begin
            if (frame_len < mrs_pkg::FRAME_BYTES) begin
               frame_buf[frame_len] = req_rx_byte;
               frame_len++;
            end else begin
               frame_ovf = 1'b1;
            end
            if (req_frame_end) begin
               run_frame();
               frame_len = 0;
               frame_ovf = 1'b0;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            words_checked++;
            if (resp_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("MISMATCH: unexpected word byte=%h last=%b",
                           rsp_tx_byte, rsp_tx_last);
            end else begin
               exp_w = resp_due.pop_front();
               if (exp_w.tx_byte !== rsp_tx_byte || exp_w.tx_last !== rsp_tx_last) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("MISMATCH: byte exp=%h act=%h last exp=%b act=%b",
                              exp_w.tx_byte, rsp_tx_byte, exp_w.tx_last, rsp_tx_last);
               end
            end
         end
      end
      pending = resp_due.size();
   end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives request frames into the Modbus RTU register slave core: directed
// corner frames, then random well-formed and broken frames with random gaps
// and receiver stalls. A checker beside the core predicts the responses.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int IDLE_LIMIT = 4000;
   localparam int HOLD_CYCLES = 400;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_rx_byte;
   logic       req_frame_end;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_tx_byte;
   logic       rsp_tx_last;
   int         fail_count, pending, words_checked;
   int         bytes_sent, frames_sent, idle_cycles;
   logic       hold_req;

   modbus_rtu_register_slave_core dut (.*);

   mrs_checker chk (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Receiver stall pattern, with one long hold-off on request
   initial begin
      int run;
      bit hold_done;
      rsp_stall = 1'b0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req && !hold_done) begin
            rsp_stall = 1'b1;
            for (int i = 0; i < HOLD_CYCLES; i++) @(negedge clock);
            hold_done = 1'b1;
         end
         if ($urandom_range(0, 2) == 0) begin
            rsp_stall = 1'b1;
            run = pick_gap();
         end else begin
            rsp_stall = 1'b0;
            run = $urandom_range(0, 20);
         end
         for (int i = 0; i < run; i++) @(negedge clock);
      end
   end

   // Watchdog on handshake progress
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Send one frame word by word; valid stays up across back-to-back words
   task automatic send_frame(input logic [7:0] f [$]);
      int gap;
      foreach (f[i]) begin
         gap = pick_gap();
         if (gap > 0) begin
            req_valid = 1'b0;
            for (int g = 0; g < gap; g++) @(negedge clock);
         end
         req_valid = 1'b1;
         req_rx_byte = f[i];
         req_frame_end = (i == f.size() - 1);
         do @(posedge clock); while (req_stall);
         bytes_sent++;
         @(negedge clock);
      end
      req_valid = 1'b0;
      frames_sent++;
   endtask

   task automatic add_crc(ref logic [7:0] f [$]);
      logic [15:0] c;
      c = chk.modbus_crc(f, f.size());
      f.push_back(c[7:0]);
      f.push_back(c[15:8]);
   endtask

   // Request frame of a given function; pad adds bytes before the CRC
   task automatic send_req(input logic [7:0] fn, input int start, input int count,
                           input int pad, input bit bad_crc);
      logic [7:0] f [$];
      f.push_back(8'($urandom));
      f.push_back(fn);
      f.push_back(8'($urandom));
      f.push_back(8'(start));
      f.push_back(8'($urandom));
      f.push_back(8'(count));
      if (fn == mrs_pkg::FN_WRITE_MULT) begin
         f.push_back(8'($urandom));
         for (int i = 0; i < 2 * count; i++) f.push_back(8'($urandom));
      end
      for (int i = 0; i < pad; i++) f.push_back(8'($urandom));
      add_crc(f);
      if (bad_crc) f[f.size() - 1 - $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
      send_frame(f);
   endtask

   // Arbitrary bytes, optionally closed with a good CRC
   task automatic send_raw(input int len, input bit with_crc);
      logic [7:0] f [$];
      for (int i = 0; i < len; i++) f.push_back(8'($urandom));
      if (with_crc) add_crc(f);
      send_frame(f);
   endtask

   function automatic logic [7:0] rand_fn();
      case ($urandom_range(0, 3))
         0: return mrs_pkg::FN_READ_HOLD;
         1: return mrs_pkg::FN_READ_INPUT;
         2: return mrs_pkg::FN_WRITE_ONE;
         default: return mrs_pkg::FN_WRITE_MULT;
      endcase
   endfunction

   initial begin
      int start, count;
      logic [7:0] fn;
      reset = 1'b1;
      hold_req = 1'b0;
      req_valid = 1'b0;
      req_rx_byte = 8'h00;
      req_frame_end = 1'b0;
      bytes_sent = 0;
      frames_sent = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed corners
      send_req(mrs_pkg::FN_READ_HOLD, 0, mrs_pkg::NUM_REGS, 0, 0);   // read all, still zero
      send_req(mrs_pkg::FN_WRITE_MULT, 0, mrs_pkg::NUM_REGS, 0, 0);  // write all
      send_req(mrs_pkg::FN_WRITE_ONE, mrs_pkg::NUM_REGS - 1, 8'hFF, 0, 0);
      send_req(mrs_pkg::FN_READ_HOLD, 5, 0, 0, 0);                   // zero count read
      send_req(mrs_pkg::FN_WRITE_MULT, 3, 0, 0, 0);                  // zero count write
      send_req(mrs_pkg::FN_WRITE_ONE, mrs_pkg::NUM_REGS, 1, 0, 0);   // address out of range
      send_req(mrs_pkg::FN_READ_HOLD, mrs_pkg::NUM_REGS - 1, 2, 0, 0);  // range overrun
      send_req(mrs_pkg::FN_READ_HOLD, 2, 2, 0, 1);                   // bad CRC
      send_req(8'h07, 0, 1, 0, 0);                                   // unknown function
      send_raw(4, 0);                                                // short frame
      send_raw(3, 1);                                                // 5 bytes, good CRC
      send_raw(65, 0);                                               // overflow

      // Long receiver hold while reads keep coming
      hold_req = 1'b1;
      for (int i = 0; i < 4; i++) send_req(mrs_pkg::FN_READ_INPUT, 0, mrs_pkg::NUM_REGS, 0, 0);

      // Random frames, mostly well formed
      while (bytes_sent < 260) begin
         fn = rand_fn();
         count = $urandom_range(0, 4) == 0 ? $urandom_range(0, mrs_pkg::NUM_REGS)
                                           : $urandom_range(0, 4);
         start = $urandom_range(0, mrs_pkg::NUM_REGS - count);
         case ($urandom_range(0, 19))
            0: send_req(fn, start, count, 0, 1);
            1: send_raw($urandom_range(1, 7), $urandom_range(0, 1));
            2: send_raw($urandom_range(65, 72), 0);
            3: send_req(8'($urandom), start, count, 0, 0);
            4: send_req(fn, $urandom_range(0, 255), $urandom_range(0, 255), 0, 0);
            5: send_req(fn, start, count, $urandom_range(1, 3), 0);
            default: send_req(fn, start, count, 0, 0);
         endcase
      end

      wait (pending == 0);
      repeat (200) @(posedge clock);
      $display("Covered %0d frames, %0d request words, %0d response words checked",
               frames_sent, bytes_sent, words_checked);
      if (fail_count == 0 && pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
